### hdl/bmg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_pkg
// Types and constants shared by the Box-Muller sample generator.
// ----------------------------------------------------------------------------
package bmg_pkg;

    typedef struct packed {
        logic [31:0] uniform_radius;
        logic [31:0] uniform_angle;
    } bmg_in_t;

    typedef struct packed {
        logic signed [31:0] sample_q16;
        logic               from_cache;
    } bmg_out_t;

    localparam logic [0:0] REG_MEAN = 1'b0;
    localparam logic [0:0] REG_STD  = 1'b1;

    localparam logic [31:0] MEAN_RESET = 32'd7864320;
    localparam logic [30:0] STD_RESET  = 31'd655360;

    localparam logic [31:0] TWO_LN2_Q30  = 32'h58B90BFC;
    localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
    localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

    localparam int LOG_STEPS = 28;
    localparam int ROT_STEPS = 30;

    function automatic logic signed [33:0] arctan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        unique case (i)
            5'd0: r = 34'sd843314857;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043837;
            5'd3: r = 34'sd133525159;
            5'd4: r = 34'sd67021687;
            5'd5: r = 34'sd33543516;
            5'd6: r = 34'sd16775851;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194283;
            5'd9: r = 34'sd2097149;
            default: r = 34'sd1 <<< (6'd30 - {1'b0, i});
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/box_muller_gaussian_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_muller_gaussian_generator
// Gaussian samples from pairs of uniform words by the Box-Muller transform.
// ----------------------------------------------------------------------------
// Usage: each input item on s_ carries a radius and an angle word. A
// generating item yields the cosine sample and keeps the sine partner; the
// next item returns the partner (from_cache = 1) and ignores its words.
// A generating item whose radius bits are all zero is consumed with no
// result. Mean and standard deviation are written on the cfg_ channel
// (index 0 mean, index 1 std dev); the user must do so only while the
// block is idle, since the block itself does not enforce it.
// A generating item runs these steps in order: normalizing, one leading
// zero of the radius word at a time, and normalize exit; the squaring
// steps of the logarithm; the square root, one result bit pair at a time
// plus a closing step; the CORDIC rotations; then multiplies, scaling and
// output. A replay item goes straight to the multiply, scaling and output
// steps. The block handles one item at a time.
// Reset clears the partner flag and loads the register defaults. A result
// waits in the output register while m_ready is low; the block accepts the
// next item as soon as its own result register is free.
// ----------------------------------------------------------------------------
module box_muller_gaussian_generator #(
    parameter int UNIFORM_BITS = 32
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  bmg_pkg::bmg_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output bmg_pkg::bmg_out_t m_data,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire  [0:0]        cfg_index,
    input  wire  [31:0]       cfg_data
);
    import bmg_pkg::*;

    localparam logic [31:0] MASK = 32'hFFFF_FFFF << (32 - UNIFORM_BITS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_NORM  = 10'b0000000010,
        S_LOG   = 10'b0000000100,
        S_W     = 10'b0000001000,
        S_SQRT  = 10'b0000010000,
        S_ANG   = 10'b0000100000,
        S_ROT   = 10'b0001000000,
        S_MUL   = 10'b0010000000,
        S_SCALE = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] mean_reg;
    logic [30:0] std_reg;
    logic        pending_reg;
    logic [31:0] partner_reg;
    logic [31:0] rad_reg, ang_reg;
    logic [4:0]  p_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] m_reg;
    logic [27:0] frac_reg;
    logic [63:0] v_reg, res_reg;
    logic [63:0] bit_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [63:0] prod_reg;
    logic        cache_reg;
    logic        ovalid_reg;
    bmg_out_t    out_reg;

    wire [31:0] rad_m = s_data.uniform_radius & MASK;
    wire [31:0] ang_m = s_data.uniform_angle & MASK;

    assign s_ready   = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = ovalid_reg;
    assign m_data    = out_reg;

    // Priority encode of the leading one, one bit a cycle while normalizing.
    logic [63:0] sq;
    logic [63:0] sqs;
    logic [63:0] lval;
    logic [63:0] wprod;
    logic [63:0] tb;
    logic signed [33:0] dx, dy;
    logic signed [63:0] sh;
    logic signed [33:0] ss;

    always_comb begin
        sq    = {31'd0, m_reg} * {31'd0, m_reg};
        sqs   = sq >> 31;
        lval  = ({58'd0, (6'd32 - {1'b0, p_reg})} << 28) - {36'd0, frac_reg};
        wprod = lval * {32'd0, TWO_LN2_Q30};
        tb    = res_reg + bit_reg;
        dx    = y_reg >>> cnt_reg[4:0];
        dy    = x_reg >>> cnt_reg[4:0];
        sh    = (prod_reg + 64'sd134217728) >>> 28;
        ss    = x_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                if (pending_reg) state_next = S_MUL;
                else if (rad_m != 32'd0) state_next = S_NORM;
            end
            S_NORM:  if (rad_reg[31]) state_next = S_LOG;
            S_LOG:   if (cnt_reg == 6'(LOG_STEPS - 1)) state_next = S_W;
            S_W:     state_next = S_SQRT;
            S_SQRT:  if (bit_reg == 64'd0) state_next = S_ANG;
            S_ANG:   state_next = S_ROT;
            S_ROT:   if (cnt_reg == 6'(ROT_STEPS - 1)) state_next = S_MUL;
            S_MUL:   state_next = S_SCALE;
            S_SCALE: state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mean_reg    <= MEAN_RESET;
            std_reg     <= STD_RESET;
            pending_reg <= 1'b0;
            partner_reg <= 32'd0;
            ovalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MEAN: mean_reg <= cfg_data;
                    REG_STD:  std_reg  <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (ovalid_reg && m_ready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    rad_reg   <= rad_m;
                    ang_reg   <= ang_m;
                    p_reg     <= 5'd31;
                    cache_reg <= pending_reg;
                    x_reg     <= $signed({2'b00, partner_reg}) - (partner_reg[31] ?
                                 34'sh100000000 : 34'sd0);
                end
                S_NORM: begin
                    if (!rad_reg[31]) begin
                        rad_reg <= rad_reg << 1;
                        p_reg   <= p_reg - 5'd1;
                    end else begin
                        m_reg    <= {1'b0, rad_reg};
                        frac_reg <= 28'd0;
                        cnt_reg  <= 6'd0;
                    end
                end
                S_LOG: begin
                    if (sqs[32]) begin
                        m_reg <= sqs[33:1];
                        frac_reg[5'(LOG_STEPS - 1) - cnt_reg[4:0]] <= 1'b1;
                    end else begin
                        m_reg <= sqs[32:0];
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_W: begin
                    v_reg   <= ((wprod + 64'd536870912) >> 30) << 28;
                    res_reg <= 64'd0;
                    bit_reg <= 64'd1 << 62;
                end
                S_SQRT: begin
                    // The closing cycle with no bit left must keep the root.
                    if (bit_reg != 64'd0) begin
                        if (bit_reg > v_reg && res_reg == 64'd0) begin
                            bit_reg <= bit_reg >> 2;
                        end else if (v_reg >= tb) begin
                            v_reg   <= v_reg - tb;
                            res_reg <= (res_reg >> 1) + bit_reg;
                            bit_reg <= bit_reg >> 2;
                        end else begin
                            res_reg <= res_reg >> 1;
                            bit_reg <= bit_reg >> 2;
                        end
                    end
                end
                S_ANG: begin
                    x_reg   <= 34'(($unsigned(res_reg) * {32'd0, INV_GAIN_Q32}
                               + 64'h80000000) >> 32);
                    y_reg   <= 34'sd0;
                    z_reg   <= 34'((({32'd0, 2'b00, ang_reg[29:0]} *
                               {32'd0, HALF_PI_Q30}) + 64'd536870912) >> 30);
                    cnt_reg <= 6'd0;
                end
                S_ROT: begin
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - arctan_q30(cnt_reg[4:0]);
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + arctan_q30(cnt_reg[4:0]);
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_MUL: begin
                    if (cache_reg) begin
                        prod_reg    <= 64'(ss) * $signed({33'd0, std_reg});
                        pending_reg <= 1'b0;
                    end else begin
                        unique case (ang_reg[31:30])
                            2'd0: begin
                                prod_reg    <= 64'(x_reg) * $signed({33'd0, std_reg});
                                partner_reg <= y_reg[31:0];
                            end
                            2'd1: begin
                                prod_reg    <= 64'(-y_reg) * $signed({33'd0, std_reg});
                                partner_reg <= x_reg[31:0];
                            end
                            2'd2: begin
                                prod_reg    <= 64'(-x_reg) * $signed({33'd0, std_reg});
                                partner_reg <= 32'(-y_reg);
                            end
                            default: begin
                                prod_reg    <= 64'(y_reg) * $signed({33'd0, std_reg});
                                partner_reg <= 32'(-x_reg);
                            end
                        endcase
                        pending_reg <= 1'b1;
                    end
                end
                S_SCALE: begin
                    prod_reg <= sh + 64'($signed(mean_reg));
                end
                S_OUT: begin
                    ovalid_reg <= 1'b1;
                    out_reg.from_cache <= cache_reg;
                    if (prod_reg > 64'sd2147483647)
                        out_reg.sample_q16 <= 32'sh7FFFFFFF;
                    else if (prod_reg < -64'sd2147483648)
                        out_reg.sample_q16 <= 32'sh80000000;
                    else
                        out_reg.sample_q16 <= prod_reg[31:0];
                end
                default: ;
            endcase
        end
    end

    ap_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("item accepted while busy");
    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped under stall");
    ap_cache_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL && cache_reg) |=> !pending_reg)
        else $error("partner flag not cleared");
    ap_out_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |=> m_valid)
        else $error("result not raised");
endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for box_muller_gaussian_generator. Uniform word
// pairs are pushed through the s_ channel with random gaps. A fixed-point
// model of the logarithm, square root and CORDIC stages predicts every
// sample, and each m_ item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import bmg_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_TICKS = 150;
    localparam int HOLD_TICKS   = 400;

    localparam longint ARCTAN_Q30 [10] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    bmg_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    bmg_out_t m_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_index;
    logic     [31:0] cfg_data;

    // Shadow of the block's registers and partner store.
    logic     [31:0] mean_r;
    logic     [30:0] std_r;
    logic     [31:0] partner_q;
    logic     partner_pending;

    bmg_out_t pending_samples[$];
    int       tx_idle_pct;
    int       rx_idle_pct;
    bit       hold_request;
    int       fail_count;
    int       sample_count;
    int       replay_count;
    int       idle_ticks;

    box_muller_gaussian_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint unsigned neg_log2_q28(input logic [31:0] rad);
        int p;
        longint unsigned m;
        longint unsigned frac;
        p = 31;
        frac = 0;
        while (rad[p] == 1'b0) p--;
        m = 64'(rad) << (31 - p);
        for (int k = 1; k <= 28; k++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac |= 64'd1 << (28 - k);
            end
        end
        return (64'(32 - p) << 28) - frac;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] scale_to_q16(input longint z);
        longint mu;
        longint s;
        mu = $signed(mean_r);
        s = ((z * longint'({33'd0, std_r}) + (64'sd1 <<< 27)) >>> 28) + mu;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    // Works out the sample for one accepted item and updates the partner store.
    function automatic bit predict_sample(input bmg_in_t d, output bmg_out_t r);
        longint unsigned w;
        longint unsigned radius;
        longint unsigned theta;
        longint x, y, z, dx, dy, step, cz, sz;
        r = '0;
        if (partner_pending) begin
            r.sample_q16 = scale_to_q16(longint'($signed(partner_q)));
            r.from_cache = 1'b1;
            partner_pending = 1'b0;
            return 1'b1;
        end
        if (d.uniform_radius == 32'd0) return 1'b0;
        w = (neg_log2_q28(d.uniform_radius) * 64'(TWO_LN2_Q30) + (64'd1 << 29)) >> 30;
        radius = int_sqrt(w << 28);
        theta = (64'(d.uniform_angle[29:0]) * 64'(HALF_PI_Q30) + (64'd1 << 29)) >> 30;
        x = longint'((radius * 64'(INV_GAIN_Q32) + (64'd1 << 31)) >> 32);
        y = 0;
        z = longint'(theta);
        for (int i = 0; i < 30; i++) begin
            step = (i < 10) ? ARCTAN_Q30[i] : (64'sd1 <<< (30 - i));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end
        end
        case (d.uniform_angle[31:30])
            2'd0: begin cz = x;  sz = y;  end
            2'd1: begin cz = -y; sz = x;  end
            2'd2: begin cz = -x; sz = -y; end
            default: begin cz = y; sz = -x; end
        endcase
        partner_q = sz[31:0];
        partner_pending = 1'b1;
        r.sample_q16 = scale_to_q16(cz);
        r.from_cache = 1'b0;
        return 1'b1;
    endfunction

    // Prediction on accepted inputs, comparison on accepted results, watchdog.
    always @(posedge aclk) begin
        bmg_out_t want;
        bmg_out_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (pending_samples.size() == 0) begin
                    $error("result with no expected sample: %h", got);
                    fail_count++;
                end else begin
                    want = pending_samples.pop_front();
                    if (got.sample_q16 !== want.sample_q16) begin
                        $error("sample_q16 expected %0d actual %0d",
                               want.sample_q16, got.sample_q16);
                        fail_count++;
                    end
                    if (got.from_cache !== want.from_cache) begin
                        $error("from_cache expected %0d actual %0d",
                               want.from_cache, got.from_cache);
                        fail_count++;
                    end
                end
                sample_count++;
                if (got.from_cache) replay_count++;
            end
            if (s_valid && s_ready) begin
                if (predict_sample(s_data, want)) pending_samples.push_back(want);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MEAN) mean_r = cfg_data;
                else std_r = cfg_data[30:0];
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_ticks = 0;
            else
                idle_ticks++;
            if (idle_ticks >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("box_muller_gaussian_generator verification failed");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int n = 0; n < HOLD_TICKS; n++) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input bmg_in_t d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_words(input logic [31:0] rad, input logic [31:0] ang);
        bmg_in_t d;
        d.uniform_radius = rad;
        d.uniform_angle  = ang;
        send_item(d);
    endtask

    // Waits until every sample is back and a rejected item has surely finished.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic bmg_in_t random_item();
        bmg_in_t d;
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) d.uniform_radius = 32'd0;
        else if (sel < 30) d.uniform_radius = $urandom >> $urandom_range(31);
        else d.uniform_radius = $urandom;
        d.uniform_angle = $urandom;
        return d;
    endfunction

    task automatic test_directed();
        send_words(32'hFFFF_FFFF, 32'h0000_0000);
        send_words(32'h1234_5678, 32'h1234_5678);
        send_words(32'h0000_0001, 32'h4000_0000);
        send_words(32'h0000_0000, 32'h0000_0000);
        // A zero radius is rejected only when the item would generate.
        send_words(32'h0000_0000, 32'hFFFF_FFFF);
        send_words(32'h0000_0000, 32'h8000_0000);
        send_words(32'h8000_0000, 32'h8000_0000);
        send_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_words(32'h0000_0001, 32'hC000_0000);
        send_words(32'hAAAA_AAAA, 32'h5555_5555);
        send_words(32'h5555_5555, 32'h3FFF_FFFF);
        send_words(32'h0000_0001, 32'h7FFF_FFFF);
        send_words(32'h0001_0000, 32'hBFFF_FFFF);
        send_words(32'h4000_0000, 32'hE000_0000);
        drain();
    endtask

    task automatic test_register_extremes();
        logic [31:0] means [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        logic [31:0] stds  [4] = '{32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001};
        for (int c = 0; c < 4; c++) begin
            write_reg(REG_MEAN, means[c]);
            write_reg(REG_STD, stds[c]);
            send_words(32'h0000_0001, 32'h0000_0000);
            send_words(32'h0, 32'h0);
            send_words(32'h0000_0001, 32'h8000_0000);
            for (int n = 0; n < 7; n++) send_item(random_item());
            drain();
        end
    endtask

    task automatic test_random(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            write_reg(REG_MEAN, $urandom);
            write_reg(REG_STD, ($urandom_range(3) == 0) ? $urandom
                                                       : $urandom_range(32'h0040_0000));
            // One phase runs with both sides always willing.
            tx_idle_pct = (ph == 1) ? 0 : 33;
            rx_idle_pct = (ph == 1) ? 0 : 33;
            for (int n = 0; n < per_phase; n++) send_item(random_item());
            drain();
        end
        tx_idle_pct = 33;
        rx_idle_pct = 33;
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        hold_request = 1'b1;
        for (int n = 0; n < 30; n++) send_item(random_item());
        drain();
        tx_idle_pct = 33;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_MEAN;
        cfg_data     = '0;
        mean_r       = MEAN_RESET;
        std_r        = STD_RESET;
        partner_q    = '0;
        partner_pending = 1'b0;
        tx_idle_pct  = 33;
        rx_idle_pct  = 33;
        hold_request = 1'b0;
        fail_count   = 0;
        sample_count = 0;
        replay_count = 0;
        idle_ticks   = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_extremes();
        test_random(6, 140);
        test_output_stall();

        $display("Covered %0d samples (%0d replayed partners) over directed, extreme-register,",
                 sample_count, replay_count);
        $display("random and output-stall runs with random gaps on both sides.");
        if (fail_count == 0) begin
            $display("box_muller_gaussian_generator verification clean");
        end else begin
            $display("box_muller_gaussian_generator verification failed");
        end
        $finish;
    end
endmodule
